// ===== sv/baro_temp_press_compensation_defines.svh =====
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_defines
// assertion macros shared by the compensation block
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESS_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESS_COMPENSATION_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define BTPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("btpc assertion failed");

// condition in this cycle implies consequence in the next cycle
`define BTPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("btpc assertion failed");

`endif

// ===== sv/btpc_pkg.sv =====
// ----------------------------------------------------------------------------
// btpc_pkg
// types and constants of the barometric compensation pipeline
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_T1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_T23  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P12  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P34  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P56  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_P78  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_P9   = 3'd6;

    // pipeline depth from the request inputs to the result register
    localparam int LATENCY  = 84;
    localparam int DIV_BITS = 64;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_req;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } t_rsp;

    // one step of the restoring divider
    typedef struct packed {
        logic [63:0] dq;
        logic [30:0] rem;
        logic [30:0] md;
        logic        neg;
    } t_div;

endpackage

// ===== sv/baro_temp_press_compensation.sv =====
// throughput: one request per cycle while the result side is not stalled
// the pressure path runs through a 64-step restoring divider, one quotient bit per stage
// a stalled result freezes the whole pipeline, nothing is lost or repeated
// reset clears the valid bits and the calibration registers to zero
// ----------------------------------------------------------------------------
// baro_temp_press_compensation
// pipelined temperature and pressure compensation from raw sensor readings
// ----------------------------------------------------------------------------
`include "baro_temp_press_compensation_defines.svh"

module baro_temp_press_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [btpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  btpc_pkg::t_req                i_req,
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    output btpc_pkg::t_rsp                o_rsp,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_stall
);
    import btpc_pkg::*;

    // calibration registers
    logic [15:0] r_t1;
    logic [31:0] r_t23, r_p12, r_p34, r_p56, r_p78;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1  <= '0;
            r_t23 <= '0;
            r_p12 <= '0;
            r_p34 <= '0;
            r_p56 <= '0;
            r_p78 <= '0;
            r_p9  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_T1:  r_t1  <= i_cfg_data[15:0];
                CFG_T23: r_t23 <= i_cfg_data;
                CFG_P12: r_p12 <= i_cfg_data;
                CFG_P34: r_p34 <= i_cfg_data;
                CFG_P56: r_p56 <= i_cfg_data;
                CFG_P78: r_p78 <= i_cfg_data;
                CFG_P9:  r_p9  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic        [15:0] w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic        [31:0] w_p8x, w_p9x;
    logic signed [63:0] w_p4_64, w_p7_64;

    assign w_t1 = r_t1;
    assign w_t2 = r_t23[15:0];
    assign w_t3 = r_t23[31:16];
    assign w_p1 = r_p12[15:0];
    assign w_p2 = r_p12[31:16];
    assign w_p3 = r_p34[15:0];
    assign w_p4 = r_p34[31:16];
    assign w_p5 = r_p56[15:0];
    assign w_p6 = r_p56[31:16];
    assign w_p7 = r_p78[15:0];
    assign w_p8 = r_p78[31:16];
    assign w_p9 = r_p9;
    assign w_p8x   = {{16{r_p78[31]}}, r_p78[31:16]};
    assign w_p9x   = {{16{r_p9[15]}}, r_p9};
    assign w_p4_64 = w_p4;
    assign w_p7_64 = w_p7;

    // pipeline control: one global enable, frozen only by a stalled result
    logic          w_en;
    logic [84:1]   r_vld;

    assign w_en        = !(r_vld[LATENCY] && i_rsp_stall);
    assign o_req_stall = !w_en;
    assign o_rsp_valid = r_vld[LATENCY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[83:1], i_req_valid};
        end
    end

    // ---------------- temperature ----------------
    logic signed [17:0] w_tdiff;
    logic signed [16:0] w_d;
    assign w_tdiff = $signed({1'b0, i_req.raw_temperature[19:3]})
                   - $signed({1'b0, w_t1, 1'b0});
    assign w_d     = $signed({1'b0, i_req.raw_temperature[19:4]})
                   - $signed({1'b0, w_t1});

    logic signed [33:0] r1_ta, r1_dd;
    logic        [19:0] r1_rp, r2_rp, r3_rp, r4_rp, r5_rp, r6_rp, r7_rp, r8_rp;
    logic signed [22:0] r2_a;
    logic signed [37:0] r2_bm;
    logic signed [21:0] w_dds;
    logic signed [24:0] r3_tfine;
    logic signed [27:0] w_tf28, w_t5;
    logic signed [19:0] w_tr;
    logic signed [15:0] w_tsat;
    logic signed [25:0] r4_v1;

    assign w_dds  = r1_dd[33:12];
    assign w_tf28 = {{3{r3_tfine[24]}}, r3_tfine};
    assign w_t5   = (w_tf28 <<< 2) + w_tf28 + 28'sd128;
    assign w_tr   = w_t5[27:8];

    always_comb begin
        if (w_tr > 20'sd32767) begin
            w_tsat = 16'sh7FFF;
        end else if (w_tr < -20'sd32768) begin
            w_tsat = 16'sh8000;
        end else begin
            w_tsat = w_tr[15:0];
        end
    end

    // ---------------- pressure divisor and dividend ----------------
    logic signed [51:0] r5_vsq;
    logic signed [41:0] r5_v1p5, r5_v1p2, r6_v1p5, r6_v1p2, r7_v1p2;
    logic signed [26:0] w_vlo;
    logic signed [25:0] w_vhi;
    logic signed [42:0] r6_m6l, r6_m3l;
    logic signed [41:0] r6_m6h, r6_m3h;
    logic signed [63:0] w_m6l64, w_m6h64, w_m3l64, w_m3h64, w_v1p5_64, w_v1p2_64;
    logic signed [63:0] r7_v2, r7_x3, r8_va, r8_v2, r9_w;
    logic        [63:0] r9_num0, r10_n125, r11_num;
    logic        [20:0] w_pp;
    logic        [47:0] r10_wl;
    logic        [31:0] r10_wh;
    logic        [63:0] w_den64;
    logic        [30:0] r11_den;

    assign w_vlo     = $signed({1'b0, r5_vsq[25:0]});
    assign w_vhi     = r5_vsq[51:26];
    assign w_m6l64   = r6_m6l;
    assign w_m6h64   = r6_m6h;
    assign w_m3l64   = r6_m3l;
    assign w_m3h64   = r6_m3h;
    assign w_v1p5_64 = r6_v1p5;
    assign w_v1p2_64 = r7_v1p2;
    assign w_pp      = 21'h100000 - {1'b0, r8_rp};
    assign w_den64   = {16'b0, r10_wl} + {r10_wh, 32'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ta    <= w_tdiff * w_t2;
            r1_dd    <= w_d * w_d;
            r1_rp    <= i_req.raw_pressure;

            r2_a     <= r1_ta[33:11];
            r2_bm    <= w_dds * w_t3;
            r2_rp    <= r1_rp;

            r3_tfine <= {{2{r2_a[22]}}, r2_a} + {r2_bm[37], r2_bm[37:14]};
            r3_rp    <= r2_rp;

            r4_v1    <= {r3_tfine[24], r3_tfine} - 26'd128000;
            r4_rp    <= r3_rp;

            r5_vsq   <= r4_v1 * r4_v1;
            r5_v1p5  <= r4_v1 * w_p5;
            r5_v1p2  <= r4_v1 * w_p2;
            r5_rp    <= r4_rp;

            // square split in halves so each product stays narrow
            r6_m6l   <= w_vlo * w_p6;
            r6_m6h   <= w_vhi * w_p6;
            r6_m3l   <= w_vlo * w_p3;
            r6_m3h   <= w_vhi * w_p3;
            r6_v1p5  <= r5_v1p5;
            r6_v1p2  <= r5_v1p2;
            r6_rp    <= r5_rp;

            r7_v2    <= w_m6l64 + (w_m6h64 <<< 26) + (w_v1p5_64 <<< 17)
                      + (w_p4_64 <<< 35);
            r7_x3    <= w_m3l64 + (w_m3h64 <<< 26);
            r7_v1p2  <= r6_v1p2;
            r7_rp    <= r6_rp;

            r8_va    <= (r7_x3 >>> 8) + (w_v1p2_64 <<< 12);
            r8_v2    <= r7_v2;
            r8_rp    <= r7_rp;

            r9_w     <= r8_va + 64'sh0000_8000_0000_0000;
            r9_num0  <= {12'b0, w_pp, 31'b0} - r8_v2;

            r10_wl   <= r9_w[31:0] * w_p1;
            r10_wh   <= r9_w[63:32] * {16'b0, w_p1};
            r10_n125 <= (r9_num0 << 7) - (r9_num0 << 1) - r9_num0;

            r11_den  <= w_den64[63:33];
            r11_num  <= (r10_n125 << 4) + (r10_n125 << 3) + r10_n125;
        end
    end

    // temperature and invalid flag ride alongside the pressure path
    logic signed [15:0] r_temp [4:83];
    logic               r_inv  [12:83];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_temp[4] <= w_tsat;
            for (int k = 4; k < 83; k++) begin
                r_temp[k+1] <= r_temp[k];
            end
            r_inv[12] <= (r11_den == '0);
            for (int k = 12; k < 83; k++) begin
                r_inv[k+1] <= r_inv[k];
            end
        end
    end

    // ---------------- divider ----------------
    t_div r_div [0:DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_div[0].neg <= r11_num[63] ^ r11_den[30];
            r_div[0].dq  <= r11_num[63] ? 64'd0 - r11_num : r11_num;
            r_div[0].md  <= r11_den[30] ? 31'd0 - r11_den : r11_den;
            r_div[0].rem <= '0;
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        logic [31:0] w_sh;
        logic        w_ge;
        logic [31:0] w_diff;
        assign w_sh   = {r_div[j].rem, r_div[j].dq[63]};
        assign w_ge   = w_sh >= {1'b0, r_div[j].md};
        assign w_diff = w_sh - {1'b0, r_div[j].md};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[j+1].neg <= r_div[j].neg;
                r_div[j+1].md  <= r_div[j].md;
                r_div[j+1].rem <= w_ge ? w_diff[30:0] : w_sh[30:0];
                r_div[j+1].dq  <= {r_div[j].dq[62:0], w_ge};
            end
        end
    end

    // ---------------- pressure correction ----------------
    logic signed [63:0] r77_p, r78_p, r79_p, r80_p, r81_p;
    logic signed [63:0] w_s;
    logic        [63:0] r78_ssl, r79_ss;
    logic        [31:0] r78_ssm, r78_bph, r80_ah;
    logic signed [48:0] r78_bpl, r80_al;
    logic signed [63:0] w_bpl64, w_al64, w_aw;
    logic signed [63:0] r79_bw, r80_b, r81_a, r81_b, r82_sum, r83_f;
    t_rsp               r_out;

    assign w_s     = r77_p >>> 13;
    assign w_bpl64 = r78_bpl;
    assign w_al64  = r80_al;
    assign w_aw    = w_al64 + {r80_ah, 32'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r77_p   <= r_div[DIV_BITS].neg ? 64'd0 - r_div[DIV_BITS].dq
                                           : r_div[DIV_BITS].dq;

            // 64-bit wrapping products from 32-bit partials
            r78_ssl <= w_s[31:0] * w_s[31:0];
            r78_ssm <= w_s[31:0] * w_s[63:32];
            r78_bpl <= $signed({1'b0, r77_p[31:0]}) * w_p8;
            r78_bph <= r77_p[63:32] * w_p8x;
            r78_p   <= r77_p;

            r79_ss  <= r78_ssl + {r78_ssm[30:0], 1'b0, 32'b0};
            r79_bw  <= w_bpl64 + {r78_bph, 32'b0};
            r79_p   <= r78_p;

            r80_al  <= $signed({1'b0, r79_ss[31:0]}) * w_p9;
            r80_ah  <= r79_ss[63:32] * w_p9x;
            r80_b   <= r79_bw >>> 19;
            r80_p   <= r79_p;

            r81_a   <= w_aw >>> 25;
            r81_b   <= r80_b;
            r81_p   <= r80_p;

            r82_sum <= r81_p + r81_a + r81_b;

            r83_f   <= (r82_sum >>> 8) + (w_p7_64 <<< 4);

            r_out.temperature_centi <= r_temp[83];
            r_out.pressure_invalid  <= r_inv[83];
            if (r_inv[83] || r83_f[63]) begin
                r_out.pressure_q24_8 <= '0;
            end else if (|r83_f[62:32]) begin
                r_out.pressure_q24_8 <= '1;
            end else begin
                r_out.pressure_q24_8 <= r83_f[31:0];
            end
        end
    end

    assign o_rsp = r_out;

    `BTPC_ASSERT_NEXT(a_req_enters, i_req_valid && !o_req_stall, r_vld[1])
    `BTPC_ASSERT_NEXT(a_stall_freezes, o_req_stall, $stable(r_vld))
    `BTPC_ASSERT_NOW(a_invalid_zero, o_rsp_valid && o_rsp.pressure_invalid, o_rsp.pressure_q24_8 == 32'd0)

endmodule

// ===== tb/baro_temp_press_compensation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_checker
// watches the calibration, request and result channels, works out the
// compensated readings for every accepted request and compares each result
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [btpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  btpc_pkg::t_req                  i_req,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  btpc_pkg::t_rsp                  i_rsp,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_stall,
    output int                              o_pending,
    output int                              o_errors
);
    import btpc_pkg::*;

    logic [15:0] cal_t1;
    logic [31:0] cal_t23, cal_p12, cal_p34, cal_p56, cal_p78;
    logic [15:0] cal_p9;

    t_rsp readings_due[$];
    int   err_cnt;

    assign o_pending = readings_due.size();
    assign o_errors  = err_cnt;

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr(input logic [63:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] div_trunc(input logic [63:0] num,
                                              input logic [63:0] den);
        logic [63:0] mn, md, q;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        q  = mn / md;
        return (num[63] != den[63]) ? -q : q;
    endfunction

    function automatic t_rsp compensate(input t_req rq);
        logic [63:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, b, d, tfine, t, v1, v2, p;
        t_rsp r;
        rt = {44'd0, rq.raw_temperature};
        rp = {44'd0, rq.raw_pressure};
        t1 = {48'd0, cal_t1};
        t2 = sext16(cal_t23[15:0]);
        t3 = sext16(cal_t23[31:16]);
        p1 = {48'd0, cal_p12[15:0]};
        p2 = sext16(cal_p12[31:16]);
        p3 = sext16(cal_p34[15:0]);
        p4 = sext16(cal_p34[31:16]);
        p5 = sext16(cal_p56[15:0]);
        p6 = sext16(cal_p56[31:16]);
        p7 = sext16(cal_p78[15:0]);
        p8 = sext16(cal_p78[31:16]);
        p9 = sext16(cal_p9);

        a = asr(((rt >> 3) - (t1 << 1)) * t2, 11);
        d = (rt >> 4) - t1;
        b = asr(asr(d * d, 12) * t3, 14);
        tfine = a + b;
        t = asr(tfine * 64'd5 + 64'd128, 8);
        if ($signed(t) < -64'sd32768)
            r.temperature_centi = 16'sh8000;
        else if ($signed(t) > 64'sd32767)
            r.temperature_centi = 16'sh7fff;
        else
            r.temperature_centi = t[15:0];

        v1 = tfine - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            r.pressure_invalid = 1'b1;
            r.pressure_q24_8   = 32'd0;
        end else begin
            r.pressure_invalid = 1'b0;
            p = 64'd1048576 - rp;
            p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
            a = asr(p9 * asr(p, 13) * asr(p, 13), 25);
            b = asr(p8 * p, 19);
            p = asr(p + a + b, 8) + (p7 << 4);
            if (p[63])
                r.pressure_q24_8 = 32'd0;
            else if (p > 64'hffff_ffff)
                r.pressure_q24_8 = 32'hffff_ffff;
            else
                r.pressure_q24_8 = p[31:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            cal_t1  <= '0;
            cal_t23 <= '0;
            cal_p12 <= '0;
            cal_p34 <= '0;
            cal_p56 <= '0;
            cal_p78 <= '0;
            cal_p9  <= '0;
            readings_due.delete();
            err_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_T1:  cal_t1  <= i_cfg_data[15:0];
                    CFG_T23: cal_t23 <= i_cfg_data;
                    CFG_P12: cal_p12 <= i_cfg_data;
                    CFG_P34: cal_p34 <= i_cfg_data;
                    CFG_P56: cal_p56 <= i_cfg_data;
                    CFG_P78: cal_p78 <= i_cfg_data;
                    CFG_P9:  cal_p9  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (readings_due.size() == 0) begin
                    $error("unexpected result %h", i_rsp);
                    err_cnt++;
                end else begin
                    want = readings_due.pop_front();
                    if (i_rsp.temperature_centi !== want.temperature_centi) begin
                        $error("temperature_centi expected %0d actual %0d",
                               want.temperature_centi, i_rsp.temperature_centi);
                        err_cnt++;
                    end
                    if (i_rsp.pressure_q24_8 !== want.pressure_q24_8) begin
                        $error("pressure_q24_8 expected %h actual %h",
                               want.pressure_q24_8, i_rsp.pressure_q24_8);
                        err_cnt++;
                    end
                    if (i_rsp.pressure_invalid !== want.pressure_invalid) begin
                        $error("pressure_invalid expected %b actual %b",
                               want.pressure_invalid, i_rsp.pressure_invalid);
                        err_cnt++;
                    end
                end
            end
            // calibration only changes while idle, so current values apply
            if (i_req_valid && !i_req_stall)
                readings_due.push_back(compensate(i_req));
        end
    end
endmodule

// ===== tb/baro_temp_press_compensation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_test
// drives calibration sets and bursts of raw readings into the compensation
// pipeline under random result stalls; the checker predicts every result
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_test;
    import btpc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    t_req                  i_req = '0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_stall;
    t_rsp                  o_rsp;
    logic                  o_rsp_valid;
    logic                  i_rsp_stall = 1'b0;
    int                    pending, errors, cycles = 0;
    int                    stall_mode = 0;

    always #10 i_clk = ~i_clk;

    baro_temp_press_compensation u_top (.*);

    baro_temp_press_compensation_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_req, .i_req_valid, .i_req_stall(o_req_stall),
        .i_rsp(o_rsp), .i_rsp_valid(o_rsp_valid), .i_rsp_stall,
        .o_pending(pending), .o_errors(errors)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern: switches between none, light, heavy and long runs
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_rsp_stall <= 1'b0;
            1: i_rsp_stall <= ($urandom_range(0, 7) == 0);
            2: i_rsp_stall <= ($urandom_range(0, 1) == 0);
            default: i_rsp_stall <= ($urandom_range(0, 29) != 0);
        endcase
    end

    task automatic cal_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_calibration(input logic [15:0] c [12]);
        cal_write(CFG_T1,  {16'd0, c[0]});
        cal_write(CFG_T23, {c[2], c[1]});
        cal_write(CFG_P12, {c[4], c[3]});
        cal_write(CFG_P34, {c[6], c[5]});
        cal_write(CFG_P56, {c[8], c[7]});
        cal_write(CFG_P78, {c[10], c[9]});
        cal_write(CFG_P9,  {16'hdead, c[11]});
        // out-of-range index must be ignored
        cal_write(CFG_IDX_W'(7), $urandom);
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
        i_req_valid <= 1'b1;
        i_req       <= '{raw_temperature: rt, raw_pressure: rp};
        do @(posedge i_clk); while (o_req_stall);
    endtask

    function automatic logic [19:0] raw_pick(input logic [19:0] centre);
        case ($urandom_range(0, 5))
            0: return 20'($urandom);
            1: return $urandom_range(0, 1) ? 20'hfffff : 20'h00000;
            default: return centre + 20'($urandom_range(0, 65535)) - 20'd32768;
        endcase
    endfunction

    task automatic random_readings(input int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && left > 0; k++) begin
                send_reading(raw_pick(20'd519888), raw_pick(20'd415148));
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                i_req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        i_req_valid <= 1'b0;
    endtask

    logic [15:0] cal [12];
    logic [15:0] typical [12] = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477,
                                 -16'sd10685, 16'd3024, 16'd2855, 16'd140,
                                 -16'sd7, 16'd15500, -16'sd14600, 16'd6000};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: zero divisor everywhere
        send_reading(20'd0, 20'd0);
        send_reading(20'hfffff, 20'hfffff);
        i_req_valid <= 1'b0;
        drain();

        load_calibration(typical);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'd0, 20'd0);
        send_reading(20'hfffff, 20'hfffff);
        send_reading(20'd0, 20'hfffff);
        send_reading(20'hfffff, 20'd0);
        send_reading(20'h55555, 20'haaaaa);
        send_reading(20'haaaaa, 20'h55555);
        random_readings(230);
        drain();

        // zero P1 forces a zero divisor with live temperature
        cal = typical;
        cal[3] = 16'd0;
        load_calibration(cal);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'hfffff, 20'd1);
        random_readings(100);
        drain();

        // extremes: all ones, most negative signed words (T1 and P1 all ones), then all 7fff
        for (int i = 0; i < 12; i++) cal[i] = 16'hffff;
        load_calibration(cal);
        send_reading(20'd0, 20'd0);
        send_reading(20'hfffff, 20'hfffff);
        random_readings(150);
        drain();

        for (int i = 0; i < 12; i++) cal[i] = 16'h8000;
        cal[0] = 16'hffff;
        cal[3] = 16'hffff;
        load_calibration(cal);
        send_reading(20'd0, 20'd0);
        send_reading(20'hfffff, 20'hfffff);
        random_readings(150);
        drain();

        for (int i = 0; i < 12; i++) cal[i] = 16'h7fff;
        load_calibration(cal);
        random_readings(120);
        drain();

        // random calibration sets, each word either random or near its typical value
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < 12; i++)
                cal[i] = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                         : typical[i] + 16'($urandom_range(0, 255)) - 16'd128;
            load_calibration(cal);
            random_readings(100);
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
